/* rtl/core/tlv_stream_check_and_find_unit_macros.svh */
// assertion macros for the tlv stream check and find unit
`ifndef TLV_STREAM_CHECK_AND_FIND_UNIT_MACROS_SVH
`define TLV_STREAM_CHECK_AND_FIND_UNIT_MACROS_SVH

// plain property, sampled on clock, off during reset
`define TLV_SCF_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("tlv_scf check failed");

// implication, same clock and reset
`define TLV_SCF_ASSERT_IMPL(lbl, ante, cons) \
   `TLV_SCF_ASSERT(lbl, (ante) |-> (cons))

// implication checked in the next cycle
`define TLV_SCF_ASSERT_NEXT(lbl, ante, cons) \
   `TLV_SCF_ASSERT(lbl, (ante) |=> (cons))

`endif

/* rtl/core/tlv_scf_pkg.sv */
// types and constants shared by the tlv stream check and find unit
package tlv_scf_pkg;

   localparam logic [7:0] LONG_LENGTH_ESCAPE = 8'hff;

   localparam logic [2:0] PH_TYPE   = 3'd0;
   localparam logic [2:0] PH_LEN    = 3'd1;
   localparam logic [2:0] PH_EXT_HI = 3'd2;
   localparam logic [2:0] PH_EXT_LO = 3'd3;
   localparam logic [2:0] PH_VALUE  = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic        well_formed;
      logic        found;
      logic [15:0] value_length;
      logic [15:0] value_offset;
   } rsp_type;

endpackage

/* rtl/core/tlv_scf_in_reg.sv */
// input register holding one request transaction until the parser takes it
module tlv_scf_in_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  tlv_scf_pkg::req_type req_payload,
   input  logic                take,
   output logic                held_valid,
   output tlv_scf_pkg::req_type held_payload
);
   import tlv_scf_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type payload_ff;
   logic    load;

   assign req_stall = valid_ff & ~take;
   assign load      = req_valid & ~req_stall;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         payload_ff <= req_payload;
      end
   end

   assign held_valid   = valid_ff;
   assign held_payload = payload_ff;

endmodule

/* rtl/core/tlv_scf_parser.sv */
// parse state, target type register and per-byte update logic
module tlv_scf_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [7:0]           csr_write_data,
   input  logic                 step,
   input  tlv_scf_pkg::req_type item,
   output logic                 result_valid,
   output tlv_scf_pkg::rsp_type result
);
   import tlv_scf_pkg::*;

   logic [7:0]  target_type_ff;
   logic [2:0]  phase_ff, phase_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [15:0] byte_offset_ff, byte_offset_in;
   logic [7:0]  length_high_ff, length_high_in;
   logic        type_matches_ff, type_matches_in;
   logic [15:0] cand_length_ff, cand_length_in;
   logic [15:0] cand_offset_ff, cand_offset_in;
   logic        found_ff, found_in;
   logic [15:0] found_length_ff, found_length_in;
   logic [15:0] found_offset_ff, found_offset_in;

   logic        hdr_done;
   logic [15:0] hdr_len;
   logic [15:0] rem_dec;
   logic [15:0] offset_inc;
   logic        want;

   assign rem_dec    = remaining_ff - 16'd1;
   assign offset_inc = byte_offset_ff + 16'd1;
   assign want       = type_matches_ff & ~found_ff;

   always_comb begin
      phase_in        = phase_ff;
      remaining_in    = remaining_ff;
      length_high_in  = length_high_ff;
      type_matches_in = type_matches_ff;
      cand_length_in  = cand_length_ff;
      cand_offset_in  = cand_offset_ff;
      found_in        = found_ff;
      found_length_in = found_length_ff;
      found_offset_in = found_offset_ff;
      hdr_done        = 1'b0;
      hdr_len         = 16'd0;

      unique case (phase_ff)
         PH_TYPE: begin
            type_matches_in = (item.data_byte == target_type_ff) & ~found_ff;
            phase_in        = PH_LEN;
         end
         PH_LEN: begin
            if (item.data_byte == LONG_LENGTH_ESCAPE) begin
               phase_in = PH_EXT_HI;
            end else begin
               hdr_done = 1'b1;
               hdr_len  = {8'd0, item.data_byte};
            end
         end
         PH_EXT_HI: begin
            length_high_in = item.data_byte;
            phase_in       = PH_EXT_LO;
         end
         PH_EXT_LO: begin
            hdr_done = 1'b1;
            hdr_len  = {length_high_ff, item.data_byte};
         end
         default: begin
            remaining_in = rem_dec;
            if (rem_dec == 16'd0) begin
               phase_in = PH_TYPE;
               if (want) begin
                  found_in        = 1'b1;
                  found_length_in = cand_length_ff;
                  found_offset_in = cand_offset_ff;
               end
            end
         end
      endcase

      if (hdr_done) begin
         if (want) begin
            cand_length_in = hdr_len;
            cand_offset_in = offset_inc;
         end
         if (hdr_len == 16'd0) begin
            phase_in = PH_TYPE;
            if (want) begin
               found_in        = 1'b1;
               found_length_in = hdr_len;
               found_offset_in = offset_inc;
            end
         end else begin
            remaining_in = hdr_len;
            phase_in     = PH_VALUE;
         end
      end

      byte_offset_in = offset_inc;

      result.well_formed  = (phase_in == PH_TYPE);
      result.found        = found_in;
      result.value_length = found_in ? found_length_in : 16'd0;
      result.value_offset = found_in ? found_offset_in : 16'd0;

      // end of message returns the parse state to its reset value
      if (item.last) begin
         phase_in        = PH_TYPE;
         remaining_in    = 16'd0;
         byte_offset_in  = 16'd0;
         length_high_in  = 8'd0;
         type_matches_in = 1'b0;
         cand_length_in  = 16'd0;
         cand_offset_in  = 16'd0;
         found_in        = 1'b0;
         found_length_in = 16'd0;
         found_offset_in = 16'd0;
      end
   end

   assign result_valid = step & item.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_type_ff <= 8'd0;
      end else if (csr_write_enable) begin
         target_type_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_TYPE;
         remaining_ff    <= 16'd0;
         byte_offset_ff  <= 16'd0;
         length_high_ff  <= 8'd0;
         type_matches_ff <= 1'b0;
         cand_length_ff  <= 16'd0;
         cand_offset_ff  <= 16'd0;
         found_ff        <= 1'b0;
         found_length_ff <= 16'd0;
         found_offset_ff <= 16'd0;
      end else if (step) begin
         phase_ff        <= phase_in;
         remaining_ff    <= remaining_in;
         byte_offset_ff  <= byte_offset_in;
         length_high_ff  <= length_high_in;
         type_matches_ff <= type_matches_in;
         cand_length_ff  <= cand_length_in;
         cand_offset_ff  <= cand_offset_in;
         found_ff        <= found_in;
         found_length_ff <= found_length_in;
         found_offset_ff <= found_offset_in;
      end
   end

endmodule

/* rtl/core/tlv_scf_out_reg.sv */
// result register driving the response channel
module tlv_scf_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  tlv_scf_pkg::rsp_type result,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tlv_scf_pkg::rsp_type rsp_payload
);
   import tlv_scf_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type payload_ff;

   assign valid_in = fire | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         payload_ff <= result;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

endmodule

/* rtl/core/tlv_stream_check_and_find_unit.sv */
// top level of the tlv stream check and find unit
//
// request channel: one message byte per transaction (data_byte, last),
// with req_valid / req_stall. a message is a chain of type, length, value
// records; length 0xff is followed by a 16-bit big-endian length.
// response channel: one transaction per message, sent for the byte marked
// last: well_formed, found, value_length, value_offset of the first
// record of csr target type whose value lies inside the message.
// csr port: csr_write_enable / csr_write_data write the target type.
// a byte is held in the input register until it is taken; the parse state
// and the result register update as it is taken, and the result register
// drives rsp once the last byte of a message has been taken.
// throughput: one byte per cycle, set by the single parse state update,
// but when rsp_stall holds a pending result, bytes flow only until a
// byte marked last reaches the parser; it waits there and req_stall rises.
// reset (synchronous, active high) clears the parse state, the target
// type and both valid flags.
module tlv_stream_check_and_find_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tlv_scf_pkg::req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tlv_scf_pkg::rsp_type rsp_payload,
   input  logic                 csr_write_enable,
   input  logic [7:0]           csr_write_data
);
   import tlv_scf_pkg::*;

   logic    held_valid;
   req_type held_payload;
   logic    take;
   logic    step;
   logic    result_valid;
   rsp_type result;

   // a last byte waits while an earlier result is still stalled
   assign take = ~(held_payload.last & rsp_valid & rsp_stall);
   assign step = held_valid & take;

   tlv_scf_in_reg u_in_reg (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .take         (take),
      .held_valid   (held_valid),
      .held_payload (held_payload)
   );

   tlv_scf_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .step             (step),
      .item             (held_payload),
      .result_valid     (result_valid),
      .result           (result)
   );

   tlv_scf_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .fire        (result_valid),
      .result      (result),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

/* rtl/core/tlv_scf_checker.sv */
// port level checks for the tlv stream check and find unit, with bind
`include "tlv_stream_check_and_find_unit_macros.svh"

module tlv_scf_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input tlv_scf_pkg::rsp_type rsp_payload
);
   import tlv_scf_pkg::*;

   `TLV_SCF_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))
   `TLV_SCF_ASSERT_IMPL(a_not_found_zero, rsp_valid && !rsp_payload.found, rsp_payload.value_length == 16'd0 && rsp_payload.value_offset == 16'd0)
   `TLV_SCF_ASSERT_IMPL(a_stall_cause, req_stall, rsp_valid && rsp_stall)
   `TLV_SCF_ASSERT_IMPL(a_reset_empty, $past(reset), !rsp_valid && !req_stall)

endmodule

bind tlv_stream_check_and_find_unit tlv_scf_checker u_tlv_scf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

/* sim/tlv_stream_check_and_find_unit_tb.sv */
// testbench for the tlv stream check and find unit: directed table and random messages
`timescale 1ns / 1ps

module tlv_stream_check_and_find_unit_tb;
   import tlv_scf_pkg::*;

   typedef enum logic [1:0] {ROW_TARGET, ROW_BYTE} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      req_type      item;
      logic         fixed;
      rsp_type      fixed_rsp;
      logic [7:0]   target;
   } step_row_type;

   localparam rsp_type NO_RSP = '0;
   localparam rsp_type BAD_RSP = '{1'b0, 1'b0, 16'd0, 16'd0};

   localparam step_row_type DIRECTED_ROWS [0:27] = '{
      '{ROW_TARGET, '{8'h00, 1'b0}, 1'b0, NO_RSP, 8'h00},
      '{ROW_BYTE, '{8'h00, 1'b0}, 1'b0, NO_RSP, 8'h00},
      '{ROW_BYTE, '{8'h00, 1'b1}, 1'b1, '{1'b1, 1'b1, 16'd0, 16'd2}, 8'h00},
      '{ROW_BYTE, '{8'hff, 1'b1}, 1'b1, BAD_RSP, 8'h00},
      '{ROW_TARGET, '{8'h00, 1'b0}, 1'b0, NO_RSP, 8'hff},
      '{ROW_BYTE, '{8'hff, 1'b0}, 1'b0, NO_RSP, 8'h00},
      '{ROW_BYTE, '{8'hff, 1'b0}, 1'b0, NO_RSP, 8'h00},
      '{ROW_BYTE, '{8'h00, 1'b0}, 1'b0, NO_RSP, 8'h00},
      '{ROW_BYTE, '{8'h02, 1'b0}, 1'b0, NO_RSP, 8'h00},
      '{ROW_BYTE, '{8'haa, 1'b0}, 1'b0, NO_RSP, 8'h00},
      '{ROW_BYTE, '{8'hbb, 1'b1}, 1'b1, '{1'b1, 1'b1, 16'd2, 16'd4}, 8'h00},
      // value overruns the message end
      '{ROW_BYTE, '{8'hff, 1'b0}, 1'b0, NO_RSP, 8'h00},
      '{ROW_BYTE, '{8'h05, 1'b0}, 1'b0, NO_RSP, 8'h00},
      '{ROW_BYTE, '{8'h11, 1'b1}, 1'b1, BAD_RSP, 8'h00},
      // later match ignored
      '{ROW_BYTE, '{8'hff, 1'b0}, 1'b0, NO_RSP, 8'h00},
      '{ROW_BYTE, '{8'h01, 1'b0}, 1'b0, NO_RSP, 8'h00},
      '{ROW_BYTE, '{8'h55, 1'b0}, 1'b0, NO_RSP, 8'h00},
      '{ROW_BYTE, '{8'hff, 1'b0}, 1'b0, NO_RSP, 8'h00},
      '{ROW_BYTE, '{8'h00, 1'b1}, 1'b1, '{1'b1, 1'b1, 16'd1, 16'd2}, 8'h00},
      // target changed between records of one message
      '{ROW_BYTE, '{8'h20, 1'b0}, 1'b0, NO_RSP, 8'h00},
      '{ROW_BYTE, '{8'h00, 1'b0}, 1'b0, NO_RSP, 8'h00},
      '{ROW_TARGET, '{8'h00, 1'b0}, 1'b0, NO_RSP, 8'h20},
      '{ROW_BYTE, '{8'h20, 1'b0}, 1'b0, NO_RSP, 8'h00},
      '{ROW_BYTE, '{8'h01, 1'b0}, 1'b0, NO_RSP, 8'h00},
      '{ROW_BYTE, '{8'h77, 1'b1}, 1'b0, NO_RSP, 8'h00},
      // ends inside the escaped length
      '{ROW_BYTE, '{8'h00, 1'b0}, 1'b0, NO_RSP, 8'h00},
      '{ROW_BYTE, '{8'hff, 1'b0}, 1'b0, NO_RSP, 8'h00},
      '{ROW_BYTE, '{8'h12, 1'b1}, 1'b1, BAD_RSP, 8'h00}
   };

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_payload;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_payload;
   logic       csr_write_enable;
   logic [7:0] csr_write_data;

   // parser mirror
   logic [7:0]  target_sel = 8'h00;
   logic [2:0]  parse_phase = PH_TYPE;
   logic [15:0] owed = '0;
   logic [15:0] msg_offset = '0;
   logic [7:0]  len_high = '0;
   logic        cur_matches = 1'b0;
   logic [15:0] cand_len = '0;
   logic [15:0] cand_off = '0;
   logic        hit = 1'b0;
   logic [15:0] hit_len = '0;
   logic [15:0] hit_off = '0;

   rsp_type pending_results [$];
   rsp_type expected_rsp;
   int      mismatches = 0;
   int      sent_count = 0;
   int      results_seen = 0;
   int      rsp_wait = 0;
   int      hold_left = 0;

   tlv_stream_check_and_find_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void take_hit();
      if (cur_matches && !hit) begin
         hit = 1'b1;
         hit_len = cand_len;
         hit_off = cand_off;
      end
   endfunction

   function automatic void close_header(input logic [15:0] len);
      if (cur_matches && !hit) begin
         cand_len = len;
         cand_off = msg_offset + 16'd1;
      end
      if (len == 16'd0) begin
         take_hit();
         parse_phase = PH_TYPE;
      end else begin
         owed = len;
         parse_phase = PH_VALUE;
      end
   endfunction

   function automatic void parse_byte(input req_type item, output bit has_rsp,
                                      output rsp_type rsp);
      has_rsp = 1'b0;
      rsp = '0;
      case (parse_phase)
         PH_TYPE: begin
            cur_matches = (item.data_byte == target_sel) && !hit;
            parse_phase = PH_LEN;
         end
         PH_LEN: begin
            if (item.data_byte == LONG_LENGTH_ESCAPE) begin
               parse_phase = PH_EXT_HI;
            end else begin
               close_header({8'h00, item.data_byte});
            end
         end
         PH_EXT_HI: begin
            len_high = item.data_byte;
            parse_phase = PH_EXT_LO;
         end
         PH_EXT_LO: begin
            close_header({len_high, item.data_byte});
         end
         default: begin
            owed = owed - 16'd1;
            if (owed == 16'd0) begin
               take_hit();
               parse_phase = PH_TYPE;
            end
         end
      endcase
      msg_offset = msg_offset + 16'd1;
      if (item.last) begin
         has_rsp = 1'b1;
         rsp.well_formed = (parse_phase == PH_TYPE);
         rsp.found = hit;
         rsp.value_length = hit ? hit_len : 16'd0;
         rsp.value_offset = hit ? hit_off : 16'd0;
         parse_phase = PH_TYPE;
         owed = '0;
         msg_offset = '0;
         len_high = '0;
         cur_matches = 1'b0;
         cand_len = '0;
         cand_off = '0;
         hit = 1'b0;
         hit_len = '0;
         hit_off = '0;
      end
   endfunction

   task automatic send_byte(input req_type item, input bit fixed, input rsp_type fixed_rsp);
      int      gap;
      bit      has_rsp;
      rsp_type predicted;
      gap = ((sent_count / 50) % 4 == 3) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      parse_byte(item, has_rsp, predicted);
      if (has_rsp) begin
         pending_results.push_back(fixed ? fixed_rsp : predicted);
      end
      sent_count++;
   endtask

   task automatic write_target(input logic [7:0] value);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      target_sel = value;
   endtask

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait = 0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result with no transaction pending: %p", rsp_payload);
               mismatches++;
            end else begin
               expected_rsp = pending_results.pop_front();
               check_field("well_formed", {15'd0, expected_rsp.well_formed},
                           {15'd0, rsp_payload.well_formed});
               check_field("found", {15'd0, expected_rsp.found},
                           {15'd0, rsp_payload.found});
               check_field("value_length", expected_rsp.value_length,
                           rsp_payload.value_length);
               check_field("value_offset", expected_rsp.value_offset,
                           rsp_payload.value_offset);
            end
            results_seen++;
            // long hold-off so the block backs up into the request side
            if (results_seen % 40 == 20) begin
               hold_left = 300;
            end
            rsp_wait = ((results_seen / 8) % 3 == 2) ? 0 : $urandom_range(0, 7);
         end else if (rsp_valid && rsp_wait > 0) begin
            rsp_wait--;
         end
         if (hold_left > 0) begin
            hold_left--;
         end
         rsp_stall <= (hold_left > 0) || (rsp_wait > 0);
      end
   end

   initial begin
      logic [7:0] msg [$];
      req_type    item;
      int         n_rec;
      int         len;
      int         pick;
      int         cut;
      int         random_items;
      int         random_msgs;
      int         w;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_write_enable = 1'b0;
      csr_write_data = 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].kind == ROW_TARGET) begin
            write_target(DIRECTED_ROWS[i].target);
         end else begin
            send_byte(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].fixed_rsp);
         end
      end

      random_items = 0;
      random_msgs = 0;
      while (random_items < 550 || random_msgs < 48) begin
         if ($urandom_range(0, 7) == 0) begin
            pick = $urandom_range(0, 3);
            write_target(pick == 0 ? 8'h00 : pick == 1 ? 8'hff : 8'($urandom_range(0, 255)));
         end
         msg.delete();
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom_range(0, 255)));
         end else begin
            n_rec = $urandom_range(1, 4);
            repeat (n_rec) begin
               msg.push_back($urandom_range(0, 1) ? target_sel : 8'($urandom_range(0, 255)));
               pick = $urandom_range(0, 199);
               if (pick == 0) begin
                  len = 254;
                  msg.push_back(8'hfe);
               end else if (pick == 1) begin
                  len = 256 + $urandom_range(0, 8);
                  msg.push_back(LONG_LENGTH_ESCAPE);
                  msg.push_back(8'h01);
                  msg.push_back(8'(len));
               end else if (pick < 40) begin
                  len = $urandom_range(0, 8);
                  msg.push_back(LONG_LENGTH_ESCAPE);
                  msg.push_back(8'h00);
                  msg.push_back(8'(len));
               end else if (pick < 70) begin
                  len = 0;
                  msg.push_back(8'h00);
               end else begin
                  len = $urandom_range(1, 6);
                  msg.push_back(8'(len));
               end
               repeat (len) msg.push_back(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 4) == 0 && msg.size() > 1) begin
               cut = $urandom_range(1, msg.size() - 1);
               msg = msg[0:cut-1];
            end
         end
         foreach (msg[i]) begin
            item.data_byte = msg[i];
            item.last = (i == msg.size() - 1);
            send_byte(item, 1'b0, NO_RSP);
         end
         random_items += msg.size();
         random_msgs++;
      end
      req_valid <= 1'b0;

      for (w = 0; w < 10000 && pending_results.size() != 0; w++) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         mismatches++;
      end
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/tlv_scf_pkg.sv
rtl/core/tlv_scf_in_reg.sv
rtl/core/tlv_scf_parser.sv
rtl/core/tlv_scf_out_reg.sv
rtl/core/tlv_stream_check_and_find_unit.sv
rtl/core/tlv_scf_checker.sv
sim/tlv_stream_check_and_find_unit_tb.sv
